[design/slx_pkg.sv]
// shared types, constants and byte class functions for the scheme token lexer
package slx_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int TOK_W         = 16;
    localparam int VALUE_W       = 32;
    localparam int MAX_RESULTS   = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_HASH    = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_IDENT   = 3'd4
    } slx_mode_t;

    typedef enum logic [2:0] {
        KIND_LPAREN = 3'd0,
        KIND_RPAREN = 3'd1,
        KIND_NUMBER = 3'd2,
        KIND_IDENT  = 3'd3,
        KIND_TRUE   = 3'd4,
        KIND_FALSE  = 3'd5,
        KIND_QUOTE  = 3'd6,
        KIND_END    = 3'd7
    } slx_kind_t;

    typedef struct packed {
        slx_kind_t            kind;
        logic [TOK_W-1:0]     start;
        logic [TOK_W-1:0]     len;
        logic [VALUE_W-1:0]   value;
        logic                 too_long;
        logic                 last;
    } slx_tok_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    // identifier punctuation: ! $ % & * + - . / : < = > ? ^ _ ~
    function automatic logic is_mark(input logic [7:0] c);
        logic r;
        case (c) inside
            8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F,
            8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5E, 8'h5F, 8'h7E: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[design/scheme_token_lexer.sv]
// top level of the scheme token lexer: input register, lexer state, result queue
//
//  channel   direction  tdata                   tuser       tlast
//  s_*       in         ch [7:0]                -           final_byte
//  m_*       out        start,len,value,flag    tok_kind    run_last
//
// one byte is taken per cycle while the result queue has room for three tokens
// a byte yields zero to three tokens; the result side drains one per cycle while m_tready
// is high, so bytes that make two or three tokens can hold the input side until there is room
// a byte passes from the input register through the combinational lexer step into the queue
// aresetn is synchronous, active low, and clears pointers, counters and lexer state
// a stalled result side fills the queue and then deasserts s_tready, nothing is lost
module scheme_token_lexer #(
    parameter int POS_WIDTH = slx_pkg::POS_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // final_byte
    // token stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] tok_start, [31:16] tok_len,
                                   // [63:32] num_value, [64] too_long, rest zero
    output logic [2:0]  m_tuser,   // [2:0] tok_kind
    output logic        m_tlast    // run_last
);

    // input register
    logic                                 in_vld_reg;
    logic [7:0]                           in_ch_reg;
    logic                                 in_fin_reg;

    // lexer state
    slx_pkg::slx_mode_t                   mode_reg;
    logic [POS_WIDTH-1:0]                 pos_reg;
    logic [POS_WIDTH-1:0]                 start_reg;
    logic [slx_pkg::VALUE_W-1:0]          accum_reg;
    logic                                 sat_reg;

    slx_pkg::slx_mode_t                   mode_next;
    logic [POS_WIDTH-1:0]                 pos_next;
    logic [POS_WIDTH-1:0]                 start_next;
    logic [slx_pkg::VALUE_W-1:0]          accum_next;
    logic                                 sat_next;

    logic [slx_pkg::MAX_RESULTS-1:0]      tok_vld;
    slx_pkg::slx_tok_t [slx_pkg::MAX_RESULTS-1:0] tok;
    logic                                 room;
    logic                                 advance;
    slx_pkg::slx_tok_t                    head;

    // the held byte moves into the lexer when the queue can take its worst case
    assign advance  = in_vld_reg && room;
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg  <= s_tdata;
            in_fin_reg <= s_tlast;
        end
    end

    slx_step #(
        .POS_WIDTH (POS_WIDTH)
    ) u_step (
        .mode_i    (mode_reg),
        .pos_i     (pos_reg),
        .start_i   (start_reg),
        .accum_i   (accum_reg),
        .sat_i     (sat_reg),
        .ch_i      (in_ch_reg),
        .fin_i     (in_fin_reg),
        .mode_o    (mode_next),
        .pos_o     (pos_next),
        .start_o   (start_next),
        .accum_o   (accum_next),
        .sat_o     (sat_next),
        .tok_vld_o (tok_vld),
        .tok_o     (tok)
    );

    // lexer state updates once per byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= slx_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            accum_reg <= '0;
            sat_reg   <= 1'b0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            accum_reg <= accum_next;
            sat_reg   <= sat_next;
        end
    end

    slx_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_vld_i (advance ? tok_vld : '0),
        .wr_tok_i (tok),
        .room_o   (room),
        .rd_vld_o (m_tvalid),
        .rd_rdy_i (m_tready),
        .rd_tok_o (head)
    );

    assign m_tdata = {7'd0, head.too_long, head.value, head.len, head.start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

[design/slx_step.sv]
// per-byte lexer step: next state and up to three tokens from one byte
module slx_step #(
    parameter int POS_WIDTH = slx_pkg::POS_WIDTH_DEF
) (
    input  slx_pkg::slx_mode_t                    mode_i,
    input  logic [POS_WIDTH-1:0]                  pos_i,
    input  logic [POS_WIDTH-1:0]                  start_i,
    input  logic [slx_pkg::VALUE_W-1:0]           accum_i,
    input  logic                                  sat_i,
    input  logic [7:0]                            ch_i,
    input  logic                                  fin_i,
    output slx_pkg::slx_mode_t                    mode_o,
    output logic [POS_WIDTH-1:0]                  pos_o,
    output logic [POS_WIDTH-1:0]                  start_o,
    output logic [slx_pkg::VALUE_W-1:0]           accum_o,
    output logic                                  sat_o,
    output logic [slx_pkg::MAX_RESULTS-1:0]       tok_vld_o,
    output slx_pkg::slx_tok_t [slx_pkg::MAX_RESULTS-1:0] tok_o
);

    localparam int CW = (POS_WIDTH + 1 > slx_pkg::TOK_W + 1) ? POS_WIDTH + 1
                                                            : slx_pkg::TOK_W + 1;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [CW-1:0] TOK_MAX = CW'({slx_pkg::TOK_W{1'b1}});

    function automatic logic [slx_pkg::TOK_W-1:0] clamp(input logic [CW-1:0] v);
        return (v > TOK_MAX) ? TOK_MAX[slx_pkg::TOK_W-1:0] : v[slx_pkg::TOK_W-1:0];
    endfunction

    slx_pkg::slx_mode_t              mode;
    logic [POS_WIDTH-1:0]            pos_n;
    logic [POS_WIDTH-1:0]            start;
    logic [slx_pkg::VALUE_W-1:0]     acc;
    logic                            sat;
    logic                            used;
    logic                            is_dig;
    logic                            is_word;
    logic [POS_WIDTH-1:0]            len_now;
    logic [POS_WIDTH:0]              len_fin;
    logic [slx_pkg::VALUE_W-1:0]     acc_x10;

    assign is_dig  = slx_pkg::is_digit(ch_i);
    assign is_word = slx_pkg::is_alpha(ch_i) || slx_pkg::is_mark(ch_i);
    assign acc_x10 = (accum_i << 3) + (accum_i << 1);

    always_comb begin
        mode      = mode_i;
        start     = start_i;
        acc       = accum_i;
        sat       = sat_i;
        used      = 1'b0;
        tok_vld_o = '0;
        tok_o     = '0;
        len_now   = pos_i - start_i;

        if (pos_i != POS_MAX) begin
            pos_n = pos_i + POS_WIDTH'(1);
        end else begin
            pos_n = pos_i;
            sat   = 1'b1;
        end

        // pending token in slot 0
        unique case (mode_i)
            slx_pkg::MODE_NUMBER: begin
                if (is_dig) begin
                    acc  = acc_x10 + slx_pkg::VALUE_W'(ch_i - slx_pkg::CH_ZERO);
                    used = 1'b1;
                end else begin
                    tok_vld_o[0]   = 1'b1;
                    tok_o[0].kind  = slx_pkg::KIND_NUMBER;
                    tok_o[0].start = clamp(CW'(start_i));
                    tok_o[0].len   = clamp(CW'(len_now));
                    tok_o[0].value = accum_i;
                    mode           = slx_pkg::MODE_IDLE;
                end
            end
            slx_pkg::MODE_IDENT: begin
                if (is_word || is_dig) begin
                    used = 1'b1;
                end else begin
                    tok_vld_o[0]   = 1'b1;
                    tok_o[0].kind  = slx_pkg::KIND_IDENT;
                    tok_o[0].start = clamp(CW'(start_i));
                    tok_o[0].len   = clamp(CW'(len_now));
                    mode           = slx_pkg::MODE_IDLE;
                end
            end
            slx_pkg::MODE_COMMENT: begin
                if (ch_i == slx_pkg::CH_LF) begin
                    mode = slx_pkg::MODE_IDLE;
                end
                used = 1'b1;
            end
            slx_pkg::MODE_HASH: begin
                tok_vld_o[0]   = 1'b1;
                tok_o[0].kind  = (ch_i == slx_pkg::CH_T) ? slx_pkg::KIND_TRUE
                                                         : slx_pkg::KIND_FALSE;
                tok_o[0].start = clamp(CW'(start_i));
                tok_o[0].len   = slx_pkg::TOK_W'(2);
                mode           = slx_pkg::MODE_IDLE;
                used           = 1'b1;
            end
            default: begin
                mode = slx_pkg::MODE_IDLE;
            end
        endcase

        // fresh byte: single-char tokens in slot 1
        if (!used) begin
            if (slx_pkg::is_space(ch_i)) begin
                mode = mode;
            end else if (ch_i == slx_pkg::CH_SEMI) begin
                mode = slx_pkg::MODE_COMMENT;
            end else if (ch_i == slx_pkg::CH_LPAR || ch_i == slx_pkg::CH_RPAR ||
                         ch_i == slx_pkg::CH_QUOTE) begin
                tok_vld_o[1]   = 1'b1;
                tok_o[1].kind  = (ch_i == slx_pkg::CH_LPAR) ? slx_pkg::KIND_LPAREN :
                                 (ch_i == slx_pkg::CH_RPAR) ? slx_pkg::KIND_RPAREN :
                                                              slx_pkg::KIND_QUOTE;
                tok_o[1].start = clamp(CW'(pos_i));
                tok_o[1].len   = slx_pkg::TOK_W'(1);
            end else if (ch_i == slx_pkg::CH_HASH) begin
                mode  = slx_pkg::MODE_HASH;
                start = pos_i;
            end else if (is_dig) begin
                mode  = slx_pkg::MODE_NUMBER;
                start = pos_i;
                acc   = slx_pkg::VALUE_W'(ch_i - slx_pkg::CH_ZERO);
            end else if (is_word) begin
                mode  = slx_pkg::MODE_IDENT;
                start = pos_i;
            end
        end

        len_fin = {1'b0, pos_i} + (POS_WIDTH + 1)'(1) - {1'b0, start};

        // final byte: flush (slot 1 is free here since a paren leaves idle) and end
        if (fin_i) begin
            if (mode == slx_pkg::MODE_NUMBER || mode == slx_pkg::MODE_IDENT) begin
                tok_vld_o[1]   = 1'b1;
                tok_o[1].kind  = (mode == slx_pkg::MODE_NUMBER) ? slx_pkg::KIND_NUMBER
                                                                : slx_pkg::KIND_IDENT;
                tok_o[1].start = clamp(CW'(start));
                tok_o[1].len   = clamp(CW'(len_fin));
                tok_o[1].value = (mode == slx_pkg::MODE_NUMBER) ? acc : '0;
            end else if (mode == slx_pkg::MODE_HASH) begin
                tok_vld_o[1]   = 1'b1;
                tok_o[1].kind  = slx_pkg::KIND_FALSE;
                tok_o[1].start = clamp(CW'(start));
                tok_o[1].len   = slx_pkg::TOK_W'(1);
            end
            tok_vld_o[2]   = 1'b1;
            tok_o[2].kind  = slx_pkg::KIND_END;
            tok_o[2].start = clamp(CW'(pos_n));
        end

        for (int i = 0; i < slx_pkg::MAX_RESULTS; i++) begin
            tok_o[i].too_long = sat;
        end

        if (tok_vld_o[2]) begin
            tok_o[2].last = 1'b1;
        end else if (tok_vld_o[1]) begin
            tok_o[1].last = 1'b1;
        end else begin
            tok_o[0].last = tok_vld_o[0];
        end

        if (fin_i) begin
            mode_o  = slx_pkg::MODE_IDLE;
            pos_o   = '0;
            start_o = '0;
            accum_o = '0;
            sat_o   = 1'b0;
        end else begin
            mode_o  = mode;
            pos_o   = pos_n;
            start_o = start;
            accum_o = acc;
            sat_o   = sat;
        end
    end

endmodule

[design/slx_out_queue.sv]
// small result queue taking up to three tokens per cycle and giving one per cycle while the reader is ready
module slx_out_queue (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [slx_pkg::MAX_RESULTS-1:0]        wr_vld_i,
    input  slx_pkg::slx_tok_t [slx_pkg::MAX_RESULTS-1:0] wr_tok_i,
    output logic                                   room_o,
    output logic                                   rd_vld_o,
    input  logic                                   rd_rdy_i,
    output slx_pkg::slx_tok_t                      rd_tok_o
);

    slx_pkg::slx_tok_t                    mem_reg [slx_pkg::QUEUE_DEPTH];
    logic [slx_pkg::QPTR_W-1:0]           wr_ptr_reg;
    logic [slx_pkg::QPTR_W-1:0]           rd_ptr_reg;
    logic [slx_pkg::QCNT_W-1:0]           count_reg;
    logic [slx_pkg::QPTR_W-1:0]           off [slx_pkg::MAX_RESULTS];
    logic [slx_pkg::QCNT_W-1:0]           push_n;
    logic                                 pop;

    always_comb begin
        off[0] = '0;
        off[1] = slx_pkg::QPTR_W'(wr_vld_i[0]);
        off[2] = slx_pkg::QPTR_W'(wr_vld_i[0]) + slx_pkg::QPTR_W'(wr_vld_i[1]);
        push_n = slx_pkg::QCNT_W'(wr_vld_i[0]) + slx_pkg::QCNT_W'(wr_vld_i[1]) +
                 slx_pkg::QCNT_W'(wr_vld_i[2]);
    end

    assign rd_vld_o = (count_reg != '0);
    assign pop      = rd_vld_o && rd_rdy_i;
    assign rd_tok_o = mem_reg[rd_ptr_reg];
    assign room_o   = (count_reg <= slx_pkg::QCNT_W'(slx_pkg::QUEUE_DEPTH -
                                                     slx_pkg::MAX_RESULTS));

    always_ff @(posedge aclk) begin
        for (int i = 0; i < slx_pkg::QUEUE_DEPTH; i++) begin
            for (int j = 0; j < slx_pkg::MAX_RESULTS; j++) begin
                if (wr_vld_i[j] &&
                    slx_pkg::QPTR_W'(wr_ptr_reg + off[j]) == slx_pkg::QPTR_W'(i)) begin
                    mem_reg[i] <= wr_tok_i[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + slx_pkg::QPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + slx_pkg::QPTR_W'(pop);
            count_reg  <= count_reg + push_n - slx_pkg::QCNT_W'(pop);
        end
    end

endmodule

[tb/slx_token_checker.sv]
// token checker for the scheme token lexer: watches both channels, predicts and compares
`timescale 1ns / 100ps

module slx_token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    typedef enum logic [1:0] {
        BC_SKIP,
        BC_SPACE,
        BC_DIGIT,
        BC_WORD
    } byte_class_t;

    // lexer state as seen by the predictor
    slx_pkg::slx_mode_t lx_mode  = slx_pkg::MODE_IDLE;
    logic [15:0]        lx_pos   = '0;
    logic [15:0]        tok_pos  = '0;
    logic [31:0]        num_acc  = '0;
    logic               pos_full = 1'b0;

    slx_pkg::slx_tok_t pending_toks[$];
    int                tok_num = 0;

    function automatic byte_class_t classify(input logic [7:0] c);
        string       marks = "!$%&*+-./:<=>?^_~";
        logic [7:0]  folded;
        folded = c | 8'h20;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
            return BC_SPACE;
        if (c >= slx_pkg::CH_ZERO && c <= slx_pkg::CH_ZERO + 8'd9)
            return BC_DIGIT;
        if (folded >= 8'h61 && folded <= 8'h7A)
            return BC_WORD;
        for (int i = 0; i < marks.len(); i++)
            if (marks[i] == c)
                return BC_WORD;
        return BC_SKIP;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t token %0d: %s", $time, tok_num, what);
        errors++;
    endtask

    task automatic push_tok(input slx_pkg::slx_kind_t k, input logic [15:0] st,
                            input logic [16:0] ln, input logic [31:0] v);
        slx_pkg::slx_tok_t t;
        t.kind     = k;
        t.start    = st;
        t.len      = (ln > 17'h0FFFF) ? 16'hFFFF : ln[15:0];
        t.value    = v;
        t.too_long = pos_full;
        t.last     = 1'b0;
        pending_toks.push_back(t);
    endtask

    task automatic clear_state();
        lx_mode  = slx_pkg::MODE_IDLE;
        lx_pos   = '0;
        tok_pos  = '0;
        num_acc  = '0;
        pos_full = 1'b0;
    endtask

    // one source byte through the lexer, expected tokens appended to pending_toks
    task automatic lex_byte(input logic [7:0] c, input logic fin);
        logic [15:0]       p;
        logic              consumed;
        int                first;
        byte_class_t       bc;
        slx_pkg::slx_tok_t t;
        p        = lx_pos;
        consumed = 1'b0;
        first    = pending_toks.size();
        bc       = classify(c);

        if (lx_pos != 16'hFFFF)
            lx_pos++;
        else
            pos_full = 1'b1;

        case (lx_mode)
            slx_pkg::MODE_NUMBER: begin
                if (bc == BC_DIGIT) begin
                    num_acc  = num_acc * 32'd10 + 32'(c - slx_pkg::CH_ZERO);
                    consumed = 1'b1;
                end else begin
                    push_tok(slx_pkg::KIND_NUMBER, tok_pos,
                             {1'b0, p} - {1'b0, tok_pos}, num_acc);
                    lx_mode = slx_pkg::MODE_IDLE;
                end
            end
            slx_pkg::MODE_IDENT: begin
                if (bc == BC_DIGIT || bc == BC_WORD) begin
                    consumed = 1'b1;
                end else begin
                    push_tok(slx_pkg::KIND_IDENT, tok_pos,
                             {1'b0, p} - {1'b0, tok_pos}, '0);
                    lx_mode = slx_pkg::MODE_IDLE;
                end
            end
            slx_pkg::MODE_COMMENT: begin
                if (c == slx_pkg::CH_LF)
                    lx_mode = slx_pkg::MODE_IDLE;
                consumed = 1'b1;
            end
            slx_pkg::MODE_HASH: begin
                push_tok((c == slx_pkg::CH_T) ? slx_pkg::KIND_TRUE : slx_pkg::KIND_FALSE,
                         tok_pos, 17'd2, '0);
                lx_mode  = slx_pkg::MODE_IDLE;
                consumed = 1'b1;
            end
            default: lx_mode = slx_pkg::MODE_IDLE;
        endcase

        // a byte that ended a token is looked at again as a fresh byte
        if (!consumed && bc != BC_SPACE) begin
            if (c == slx_pkg::CH_SEMI) begin
                lx_mode = slx_pkg::MODE_COMMENT;
            end else if (c == slx_pkg::CH_LPAR) begin
                push_tok(slx_pkg::KIND_LPAREN, p, 17'd1, '0);
            end else if (c == slx_pkg::CH_RPAR) begin
                push_tok(slx_pkg::KIND_RPAREN, p, 17'd1, '0);
            end else if (c == slx_pkg::CH_QUOTE) begin
                push_tok(slx_pkg::KIND_QUOTE, p, 17'd1, '0);
            end else if (c == slx_pkg::CH_HASH) begin
                lx_mode = slx_pkg::MODE_HASH;
                tok_pos = p;
            end else if (bc == BC_DIGIT) begin
                lx_mode = slx_pkg::MODE_NUMBER;
                tok_pos = p;
                num_acc = 32'(c - slx_pkg::CH_ZERO);
            end else if (bc == BC_WORD) begin
                lx_mode = slx_pkg::MODE_IDENT;
                tok_pos = p;
            end
        end

        if (fin) begin
            if (lx_mode == slx_pkg::MODE_NUMBER)
                push_tok(slx_pkg::KIND_NUMBER, tok_pos,
                         {1'b0, p} + 17'd1 - {1'b0, tok_pos}, num_acc);
            else if (lx_mode == slx_pkg::MODE_IDENT)
                push_tok(slx_pkg::KIND_IDENT, tok_pos,
                         {1'b0, p} + 17'd1 - {1'b0, tok_pos}, '0);
            else if (lx_mode == slx_pkg::MODE_HASH)
                push_tok(slx_pkg::KIND_FALSE, tok_pos, 17'd1, '0);   // lone hash at the end
            push_tok(slx_pkg::KIND_END, lx_pos, 17'd0, '0);
            clear_state();
        end

        if (pending_toks.size() > first) begin
            t      = pending_toks.pop_back();
            t.last = 1'b1;
            pending_toks.push_back(t);
        end
    endtask

    always @(posedge aclk) begin : watch
        slx_pkg::slx_tok_t want;
        if (!aresetn) begin
            clear_state();
        end else begin
            // results first: a token can never come from the byte taken at the same edge
            if (m_tvalid && m_tready) begin
                if (pending_toks.size() == 0) begin
                    report_mismatch($sformatf("kind %0d arrived with nothing expected",
                                              m_tuser));
                end else begin
                    want = pending_toks.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  m_tuser, want.kind));
                    if (m_tdata[15:0] !== want.start)
                        report_mismatch($sformatf("start %0d, expected %0d",
                                                  m_tdata[15:0], want.start));
                    if (m_tdata[31:16] !== want.len)
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  m_tdata[31:16], want.len));
                    if (m_tdata[63:32] !== want.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  m_tdata[63:32], want.value));
                    if (m_tdata[64] !== want.too_long)
                        report_mismatch($sformatf("too_long %b, expected %b",
                                                  m_tdata[64], want.too_long));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  m_tlast, want.last));
                    if (m_tdata[71:65] !== 7'd0)
                        report_mismatch($sformatf("padding bits %b not zero",
                                                  m_tdata[71:65]));
                end
                tok_num++;
            end
            if (s_tvalid && s_tready)
                lex_byte(s_tdata, s_tlast);
            pending = pending_toks.size();
        end
    end

endmodule

[tb/tb_scheme_token_lexer.sv]
// testbench top for the scheme token lexer: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module tb_scheme_token_lexer;

    localparam int  RAND_ITEMS     = 115;
    localparam int  RX_HOLD_CYCLES = 300;
    localparam int  DRAIN_CYCLES   = 16;
    // limit for the whole run, well above the time the slowest run takes
    localparam real LIMIT_NS       = 640_000.0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int errors;
    int pending;

    // idle_off gives stretches where neither side inserts gaps
    bit idle_off    = 1'b0;
    // set by the stimulus, cleared by the receiver once its long hold-off is over
    bit rx_hold_req = 1'b0;
    int items_sent  = 0;

    logic [7:0] text_buf[$];

    scheme_token_lexer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    slx_token_checker chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard stop in case the token stream hangs
    initial begin
        #(LIMIT_NS);
        $display("[scheme_token_lexer] ERROR");
        $finish;
    end

    // one byte transfer on the input side, with a random gap in front of it
    task automatic send_byte(input logic [7:0] c, input logic fin);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // sends the buffered text, the last byte marked final
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'h09 + r[7:0];   // space or tab..cr
    endfunction

    // identifier byte; a leading one is never a digit
    function automatic logic [7:0] word_char(input bit lead);
        string marks = "!$%&*+-./:<=>?^_~";
        case ($urandom_range(0, 3))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return marks[$urandom_range(0, marks.len() - 1)];
            default: begin
                if (lead)
                    return marks[$urandom_range(0, marks.len() - 1)];
                return slx_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            end
        endcase
    endfunction

    // one random lexical piece: mostly well formed tokens, some comments and noise
    task automatic add_piece();
        int n;
        case ($urandom_range(0, 11))
            0: text_buf.push_back(slx_pkg::CH_LPAR);
            1: text_buf.push_back(slx_pkg::CH_RPAR);
            2: text_buf.push_back(slx_pkg::CH_QUOTE);
            3, 4: begin
                // long digit runs wrap the value past 32 bits
                n = $urandom_range(1, 12);
                repeat (n) text_buf.push_back(slx_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            5, 6: begin
                n = $urandom_range(0, 5);
                text_buf.push_back(word_char(1'b1));
                repeat (n) text_buf.push_back(word_char(1'b0));
            end
            7: begin
                text_buf.push_back(slx_pkg::CH_HASH);
                if ($urandom_range(0, 1))
                    text_buf.push_back(slx_pkg::CH_T);
                else
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
                n = $urandom_range(0, 4);
                text_buf.push_back(slx_pkg::CH_SEMI);
                repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
                text_buf.push_back(slx_pkg::CH_LF);
            end
            9: text_buf.push_back(space_char());
            10: text_buf.push_back(8'($urandom_range(0, 255)));   // any byte, mostly dropped
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) text_buf.push_back(space_char());
            end
        endcase
        if ($urandom_range(0, 9) < 6)
            text_buf.push_back(space_char());
    endtask

    // result side: random ready gaps, plus one long hold-off on request
    initial begin : receiver
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            gap = idle_off ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int base;
        int pieces;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every token kind, bytes 00 and ff, a comment, a number cut by
        // a letter, and a hash as the final byte
        add_str("(a1 #t#f')");
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h09);
        add_str(";x\n12z#");
        send_text();
        // hash swallows the final byte, even a paren
        text_buf.push_back(slx_pkg::CH_HASH);
        text_buf.push_back(slx_pkg::CH_RPAR);
        send_text();

        // receiver holds off while a burst of parens fills the token queue
        rx_hold_req = 1'b1;
        idle_off    = 1'b1;
        repeat (14) text_buf.push_back(slx_pkg::CH_LPAR);
        text_buf.push_back(8'h20);
        send_text();
        s_tvalid <= 1'b0;
        idle_off = 1'b0;
        // sender waits for the queue to drain completely
        while (pending != 0) @(negedge aclk);

        // random texts, some of them sent back to back without gaps
        base = items_sent;
        while (items_sent - base < RAND_ITEMS) begin
            idle_off = ($urandom_range(0, 4) == 0);
            pieces   = $urandom_range(1, 10);
            repeat (pieces) add_piece();
            if ($urandom_range(0, 7) == 0)
                text_buf.push_back(slx_pkg::CH_HASH);
            send_text();
        end

        // a paren, a number and a final hash, back to back
        idle_off = 1'b1;
        send_byte(slx_pkg::CH_LPAR, 1'b0);
        send_byte(slx_pkg::CH_ZERO + 8'd7, 1'b0);
        send_byte(slx_pkg::CH_HASH, 1'b1);
        s_tvalid <= 1'b0;
        idle_off = 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("[scheme_token_lexer] OK");
        else
            $display("[scheme_token_lexer] ERROR");
        $finish;
    end

endmodule
